// ===== rtl/oakt_pkg.sv =====
// ----------------------------------------------------------------------------
// oakt_pkg
// Types and codes shared by the open-addressed key table.
// ----------------------------------------------------------------------------
package oakt_pkg;

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_GET    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
    logic [5:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [31:0] key_out;
    logic [5:0]  entry_count;
  } res_t;

endpackage

// ===== rtl/open_addressed_key_table_unit.sv =====
// ----------------------------------------------------------------------------
// open_addressed_key_table_unit
// Integer-keyed map: linear-probed cell map over dense entry memories.
// ----------------------------------------------------------------------------
// One command is taken at a time (start while busy is low); its single result
// appears on result for exactly one cycle with done high and cannot be held.
// Set, get and remove walk the cell map one probed cell at a time: cell map
// read, entry key read on the one entry read port, then key compare. A walk
// ends on an empty cell or on a match, where get then fetches the value; remove
// first moves the last entry into the freed slot when needed, then walks the
// probe run that follows, moving entries back, and closes the gap.
// Clear finishes straight from idle; read-at-index makes one entry memory read.
module open_addressed_key_table_unit
  import oakt_pkg::*;
#(
  parameter int TABLE_CELLS = 64,
  parameter int ITEM_LIMIT  = 44,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int CB = $clog2(TABLE_CELLS);
  localparam int SB = $clog2(ITEM_LIMIT);
  localparam int NB = $clog2(ITEM_LIMIT + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P0   = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_GV   = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_S0   = 4'd7;
  localparam logic [3:0] S_S1   = 4'd8;
  localparam logic [3:0] S_S2   = 4'd9;

  // memories
  logic [SB-1:0]         cmap  [TABLE_CELLS];
  logic [KEY_BITS-1:0]   ekey  [ITEM_LIMIT];
  logic [VALUE_BITS-1:0] evalm [ITEM_LIMIT];
  logic [CB-1:0]         ehome [ITEM_LIMIT];

  logic [SB-1:0]         cmap_q;
  logic [KEY_BITS-1:0]   ekey_q;
  logic [VALUE_BITS-1:0] eval_q;
  logic [CB-1:0]         ehome_q;

  logic                  cmap_we;
  logic [CB-1:0]         cmap_waddr, cmap_raddr;
  logic [SB-1:0]         cmap_wdata;
  logic [SB-1:0]         eaddr, ewaddr;
  logic                  ekey_we, eval_we, ehome_we;
  logic [KEY_BITS-1:0]   ekey_wdata;
  logic [VALUE_BITS-1:0] eval_wdata;
  logic [CB-1:0]         ehome_wdata;

  // registers
  logic [3:0]            state, state_next;
  logic [NB-1:0]         live_count, live_count_next;
  logic [TABLE_CELLS-1:0] cvalid, cvalid_next;
  logic                  done_next;
  logic [2:0]            mode_r, mode_r_next;
  logic [KEY_BITS-1:0]   key_r, key_r_next;
  logic [VALUE_BITS-1:0] val_r, val_r_next;
  logic [CB-1:0]         cr, cr_next, n, n_next, i_r, i_r_next, j_r, j_r_next;
  logic [SB-1:0]         slot_r, slot_r_next;
  logic [1:0]            status, status_next;
  logic [31:0]           vout, vout_next, kout, kout_next;

  // comb helpers
  logic [63:0]           key64, val64, ekey64, eval64;
  logic [KEY_BITS-1:0]   key_w;
  logic [VALUE_BITS-1:0] val_w;
  logic [31:0]           idx32, cnt32;
  logic [NB-1:0]         last;
  logic [CB-1:0]         jn, k;
  logic                  fin, miss, walk_full, found, move;

  assign key64  = {32'b0, cmd.key};
  assign val64  = {32'b0, cmd.value};
  assign key_w  = key64[KEY_BITS-1:0];
  assign val_w  = val64[VALUE_BITS-1:0];
  assign ekey64 = 64'(ekey_q);
  assign eval64 = 64'(eval_q);
  assign idx32  = 32'(cmd.entry_index);
  assign cnt32  = 32'(live_count);
  assign last   = live_count - NB'(1);
  assign jn     = j_r + CB'(1);
  assign k      = ekey64[CB-1:0];

  assign busy               = (state != S_IDLE);
  assign result.status      = status;
  assign result.value_out   = vout;
  assign result.key_out     = kout;
  assign result.entry_count = cnt32[5:0];

  always_comb begin
    state_next      = state;
    live_count_next = live_count;
    cvalid_next     = cvalid;
    mode_r_next     = mode_r;
    key_r_next      = key_r;
    val_r_next      = val_r;
    cr_next         = cr;
    n_next          = n;
    i_r_next        = i_r;
    j_r_next        = j_r;
    slot_r_next     = slot_r;
    status_next     = status;
    vout_next       = vout;
    kout_next       = kout;
    cmap_we         = 1'b0;
    cmap_waddr      = '0;
    cmap_wdata      = '0;
    cmap_raddr      = '0;
    eaddr           = '0;
    ewaddr          = '0;
    ekey_we         = 1'b0;
    eval_we         = 1'b0;
    ehome_we        = 1'b0;
    ekey_wdata      = '0;
    eval_wdata      = '0;
    ehome_wdata     = '0;
    fin             = 1'b0;
    miss            = 1'b0;
    walk_full       = 1'b0;
    found           = 1'b0;
    move            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          mode_r_next = cmd.mode;
          key_r_next  = key_w;
          val_r_next  = val_w;
          cr_next     = key_w[CB-1:0];
          n_next      = '0;
          status_next = ST_OK;
          vout_next   = '0;
          kout_next   = '0;
          case (cmd.mode)
            MODE_SET, MODE_GET, MODE_REMOVE: state_next = S_P0;
            MODE_CLEAR: begin
              cvalid_next     = '0;
              live_count_next = '0;
              fin             = 1'b1;
            end
            MODE_READ: begin
              if (idx32 < cnt32 && idx32 < 32'(ITEM_LIMIT)) begin
                eaddr      = idx32[SB-1:0];
                state_next = S_RD;
              end else begin
                status_next = ST_RANGE;
                fin         = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_P0: begin
        if (!cvalid[cr]) begin
          miss = 1'b1;
        end else begin
          cmap_raddr = cr;
          state_next = S_P1;
        end
      end
      S_P1: begin
        slot_r_next = cmap_q;
        eaddr       = cmap_q;
        state_next  = S_P2;
      end
      S_P2: begin
        if (ekey_q == key_r) begin
          found = 1'b1;
        end else if (n == CB'(TABLE_CELLS - 1)) begin
          miss      = 1'b1;
          walk_full = 1'b1;
        end else begin
          n_next     = n + CB'(1);
          cr_next    = cr + CB'(1);
          state_next = S_P0;
        end
      end
      S_GV: begin
        vout_next = eval64[31:0];
        fin       = 1'b1;
      end
      S_RD: begin
        vout_next = eval64[31:0];
        kout_next = ekey64[31:0];
        fin       = 1'b1;
      end
      S_M1: begin
        ewaddr      = slot_r;
        ekey_we     = 1'b1;
        eval_we     = 1'b1;
        ehome_we    = 1'b1;
        ekey_wdata  = ekey_q;
        eval_wdata  = eval_q;
        ehome_wdata = ehome_q;
        cmap_we     = 1'b1;
        cmap_waddr  = ehome_q;
        cmap_wdata  = slot_r;
        state_next  = S_S0;
      end
      S_S0: begin
        if (n == CB'(TABLE_CELLS - 1)) begin
          cvalid_next[i_r] = 1'b0;
          fin              = 1'b1;
        end else begin
          j_r_next = jn;
          n_next   = n + CB'(1);
          if (!cvalid[jn]) begin
            cvalid_next[i_r] = 1'b0;
            fin              = 1'b1;
          end else begin
            cmap_raddr = jn;
            state_next = S_S1;
          end
        end
      end
      S_S1: begin
        slot_r_next = cmap_q;
        eaddr       = cmap_q;
        state_next  = S_S2;
      end
      S_S2: begin
        move = (j_r > i_r && (k <= i_r || k > j_r)) ||
               (j_r < i_r && (k <= i_r && k > j_r));
        if (move) begin
          ewaddr      = slot_r;
          ehome_we    = 1'b1;
          ehome_wdata = i_r;
          cmap_we     = 1'b1;
          cmap_waddr  = i_r;
          cmap_wdata  = slot_r;
          i_r_next    = j_r;
        end
        state_next = S_S0;
      end
      default: state_next = S_IDLE;
    endcase

    if (miss) begin
      if (mode_r == MODE_SET) begin
        if (walk_full || live_count >= NB'(ITEM_LIMIT)) begin
          status_next = ST_FULL;
        end else begin
          cvalid_next[cr] = 1'b1;
          cmap_we         = 1'b1;
          cmap_waddr      = cr;
          cmap_wdata      = live_count[SB-1:0];
          ewaddr          = live_count[SB-1:0];
          ekey_we         = 1'b1;
          eval_we         = 1'b1;
          ehome_we        = 1'b1;
          ekey_wdata      = key_r;
          eval_wdata      = val_r;
          ehome_wdata     = cr;
          live_count_next = live_count + NB'(1);
        end
      end else begin
        status_next = ST_NOT_FOUND;
      end
      fin = 1'b1;
    end

    if (found) begin
      case (mode_r)
        MODE_SET: begin
          ewaddr     = slot_r;
          eval_we    = 1'b1;
          eval_wdata = val_r;
          fin        = 1'b1;
        end
        MODE_GET: begin
          eaddr      = slot_r;
          state_next = S_GV;
        end
        default: begin
          live_count_next = last;
          i_r_next        = cr;
          j_r_next        = cr;
          n_next          = '0;
          if (NB'(slot_r) < last) begin
            eaddr      = last[SB-1:0];
            state_next = S_M1;
          end else begin
            state_next = S_S0;
          end
        end
      endcase
    end

    done_next = fin;
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (cmap_we) cmap[cmap_waddr] <= cmap_wdata;
    cmap_q <= cmap[cmap_raddr];
  end

  always_ff @(posedge clk) begin
    if (ekey_we) ekey[ewaddr] <= ekey_wdata;
    if (eval_we) evalm[ewaddr] <= eval_wdata;
    if (ehome_we) ehome[ewaddr] <= ehome_wdata;
    ekey_q  <= ekey[eaddr];
    eval_q  <= evalm[eaddr];
    ehome_q <= ehome[eaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      cvalid     <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      live_count <= live_count_next;
      cvalid     <= cvalid_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    key_r  <= key_r_next;
    val_r  <= val_r_next;
    cr     <= cr_next;
    n      <= n_next;
    i_r    <= i_r_next;
    j_r    <= j_r_next;
    slot_r <= slot_r_next;
    status <= status_next;
    vout   <= vout_next;
    kout   <= kout_next;
  end

endmodule
